// ===== hw/rtl/p2d_pkg.sv =====
package p2d_pkg;

    localparam int MAX_ORDER = 7;
    localparam int FRAC_BITS = 16;
    localparam int ORD_W     = $clog2(MAX_ORDER + 1);
    localparam int ADDR_W    = 2 * ORD_W;
    localparam int MEM_DEPTH = (MAX_ORDER + 1) * (MAX_ORDER + 1);
    localparam int DATA_W    = 32;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = DIFF_W + DATA_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int ACC_W     = RND_W + ADDR_W;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_AZ_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RG_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_RG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_AZ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_AZ   = 3'd5;

    typedef struct packed {
        logic                     opcode;
        logic [ORD_W-1:0]         coef_row;
        logic [ORD_W-1:0]         coef_col;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] azimuth;
        logic signed [DATA_W-1:0] range;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] poly_value;
        logic                     overflow;
    } result_t;

    typedef struct packed {
        logic [ORD_W-1:0]         az_order;
        logic [ORD_W-1:0]         rg_order;
        logic signed [DATA_W-1:0] mean_rg;
        logic signed [DATA_W-1:0] mean_az;
        logic signed [DATA_W-1:0] inv_rg;
        logic signed [DATA_W-1:0] inv_az;
    } cfg_t;

    typedef enum logic [2:0] {MA_DX, MA_DY, MA_PX, MA_PY, MA_COEF} mula_sel_t;
    typedef enum logic [2:0] {MB_INVX, MB_INVY, MB_PY, MB_X, MB_Y, MB_PXY} mulb_sel_t;
    typedef enum logic [2:0] {WB_NONE, WB_X, WB_Y, WB_PX, WB_PY, WB_PXY, WB_ACC} wb_sel_t;
    typedef enum logic [1:0] {JC_NEXT, JC_ALWAYS, JC_JLAST, JC_ILAST} jmp_cond_t;

    typedef struct packed {
        logic              mul_en;
        mula_sel_t         mula_sel;
        mulb_sel_t         mulb_sel;
        wb_sel_t           wb_sel;
        logic              clr;
        logic              row_init;
        logic              inc_i;
        logic              inc_j;
        logic              mem_rd;
        logic              done;
        jmp_cond_t         jmp_cond;
        logic [STEP_W-1:0] jmp_to;
    } ctl_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
    } stat_t;

endpackage

// ===== hw/rtl/p2d_sequencer.sv =====
module p2d_sequencer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  p2d_pkg::stat_t stat,
    output p2d_pkg::ctl_t  ctl,
    output logic           busy
);
    import p2d_pkg::*;

    localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] ST_NX   = 4'd1;
    localparam logic [STEP_W-1:0] ST_WX   = 4'd2;
    localparam logic [STEP_W-1:0] ST_NY   = 4'd3;
    localparam logic [STEP_W-1:0] ST_WY   = 4'd4;
    localparam logic [STEP_W-1:0] ST_PXY  = 4'd5;
    localparam logic [STEP_W-1:0] ST_WPXY = 4'd6;
    localparam logic [STEP_W-1:0] ST_TERM = 4'd7;
    localparam logic [STEP_W-1:0] ST_ACC  = 4'd8;
    localparam logic [STEP_W-1:0] ST_PX   = 4'd9;
    localparam logic [STEP_W-1:0] ST_WPX  = 4'd10;
    localparam logic [STEP_W-1:0] ST_NROW = 4'd11;
    localparam logic [STEP_W-1:0] ST_PY   = 4'd12;
    localparam logic [STEP_W-1:0] ST_WPY  = 4'd13;
    localparam logic [STEP_W-1:0] ST_DONE = 4'd14;

    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t c;
        c = '0;
        unique case (step)
            ST_NX:   begin c.mul_en = 1'b1; c.mula_sel = MA_DX; c.mulb_sel = MB_INVX;
                           c.clr = 1'b1; end
            ST_WX:   c.wb_sel = WB_X;
            ST_NY:   begin c.mul_en = 1'b1; c.mula_sel = MA_DY; c.mulb_sel = MB_INVY; end
            ST_WY:   begin c.wb_sel = WB_Y; c.row_init = 1'b1; end
            ST_PXY:  begin c.mul_en = 1'b1; c.mula_sel = MA_PX; c.mulb_sel = MB_PY;
                           c.mem_rd = 1'b1; end
            ST_WPXY: c.wb_sel = WB_PXY;
            ST_TERM: begin c.mul_en = 1'b1; c.mula_sel = MA_COEF; c.mulb_sel = MB_PXY; end
            ST_ACC:  begin c.wb_sel = WB_ACC; c.jmp_cond = JC_JLAST; c.jmp_to = ST_NROW; end
            ST_PX:   begin c.mul_en = 1'b1; c.mula_sel = MA_PX; c.mulb_sel = MB_X;
                           c.inc_j = 1'b1; end
            ST_WPX:  begin c.wb_sel = WB_PX; c.jmp_cond = JC_ALWAYS; c.jmp_to = ST_PXY; end
            ST_NROW: begin c.jmp_cond = JC_ILAST; c.jmp_to = ST_DONE; end
            ST_PY:   begin c.mul_en = 1'b1; c.mula_sel = MA_PY; c.mulb_sel = MB_Y;
                           c.inc_i = 1'b1; end
            ST_WPY:  begin c.wb_sel = WB_PY; c.row_init = 1'b1; c.jmp_cond = JC_ALWAYS;
                           c.jmp_to = ST_PXY; end
            ST_DONE: begin c.done = 1'b1; c.jmp_cond = JC_ALWAYS; c.jmp_to = ST_IDLE; end
            default: c = '0;
        endcase
        return c;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    always_comb
    begin
        ctl = ucode(step_reg);
        unique case (ctl.jmp_cond)
            JC_NEXT:   taken = 1'b0;
            JC_ALWAYS: taken = 1'b1;
            JC_JLAST:  taken = stat.j_last;
            JC_ILAST:  taken = stat.i_last;
            default:   taken = 1'b0;
        endcase
        if (step_reg == ST_IDLE)
        begin
            step_next = go ? ST_NX : ST_IDLE;
        end
        else if (taken)
        begin
            step_next = ctl.jmp_to;
        end
        else
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign busy = (step_reg != ST_IDLE);

endmodule

// ===== hw/rtl/p2d_datapath.sv =====
module p2d_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  p2d_pkg::ctl_t    ctl,
    input  p2d_pkg::cfg_t    cfg,
    input  p2d_pkg::cmd_t    cmd,
    input  logic             eval_load,
    input  logic             coef_we,
    output p2d_pkg::stat_t   stat,
    output logic             done,
    output p2d_pkg::result_t result
);
    import p2d_pkg::*;

    logic signed [DATA_W-1:0] coef_mem [MEM_DEPTH];

    logic signed [DATA_W-1:0] rg_in_reg;
    logic signed [DATA_W-1:0] az_in_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] px_reg;
    logic signed [DATA_W-1:0] py_reg;
    logic signed [DATA_W-1:0] pxy_reg;
    logic signed [DATA_W-1:0] coef_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     ovf_reg;
    logic [ORD_W-1:0]         i_reg;
    logic [ORD_W-1:0]         j_reg;
    logic                     done_reg;
    result_t                  result_reg;

    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [RND_W-1:0]  rnd;
    logic [RND_W-DATA_W:0]    rnd_hi;
    logic                     rnd_fits;
    logic signed [DATA_W-1:0] rnd_sat;
    logic [ACC_W-DATA_W:0]    acc_hi;
    logic                     acc_fits;
    logic signed [DATA_W-1:0] acc_sat;

    assign diff_x = {rg_in_reg[DATA_W-1], rg_in_reg} - {cfg.mean_rg[DATA_W-1], cfg.mean_rg};
    assign diff_y = {az_in_reg[DATA_W-1], az_in_reg} - {cfg.mean_az[DATA_W-1], cfg.mean_az};

    always_comb
    begin
        case (ctl.mula_sel)
            MA_DX:   op_a = diff_x;
            MA_DY:   op_a = diff_y;
            MA_PX:   op_a = {px_reg[DATA_W-1], px_reg};
            MA_PY:   op_a = {py_reg[DATA_W-1], py_reg};
            MA_COEF: op_a = {coef_rd_reg[DATA_W-1], coef_rd_reg};
            default: op_a = '0;
        endcase
        case (ctl.mulb_sel)
            MB_INVX: op_b = cfg.inv_rg;
            MB_INVY: op_b = cfg.inv_az;
            MB_PY:   op_b = py_reg;
            MB_X:    op_b = x_reg;
            MB_Y:    op_b = y_reg;
            MB_PXY:  op_b = pxy_reg;
            default: op_b = '0;
        endcase
    end

    assign rnd_full = (prod_reg + RND_HALF) >>> FRAC_BITS;
    assign rnd      = rnd_full[RND_W-1:0];
    assign rnd_hi   = rnd[RND_W-1:DATA_W-1];
    assign rnd_fits = (&rnd_hi) | ~(|rnd_hi);
    assign rnd_sat  = rnd_fits ? rnd[DATA_W-1:0] : (rnd[RND_W-1] ? S32_MIN : S32_MAX);

    assign acc_hi   = acc_reg[ACC_W-1:DATA_W-1];
    assign acc_fits = (&acc_hi) | ~(|acc_hi);
    assign acc_sat  = acc_fits ? acc_reg[DATA_W-1:0] : (acc_reg[ACC_W-1] ? S32_MIN : S32_MAX);

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[{cmd.coef_row, cmd.coef_col}] <= cmd.coef_value;
        end
        if (ctl.mem_rd)
        begin
            coef_rd_reg <= coef_mem[{i_reg, j_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_load)
        begin
            rg_in_reg <= cmd.range;
            az_in_reg <= cmd.azimuth;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(op_a * op_b);
        end
        if (ctl.clr)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            py_reg  <= FX_ONE;
            i_reg   <= '0;
        end
        if (ctl.row_init)
        begin
            px_reg <= FX_ONE;
            j_reg  <= '0;
        end
        if (ctl.inc_i)
        begin
            i_reg <= i_reg + ORD_W'(1);
        end
        if (ctl.inc_j)
        begin
            j_reg <= j_reg + ORD_W'(1);
        end
        if ((ctl.wb_sel != WB_NONE) && (ctl.wb_sel != WB_ACC) && !rnd_fits)
        begin
            ovf_reg <= 1'b1;
        end
        case (ctl.wb_sel)
            WB_X:    x_reg   <= rnd_sat;
            WB_Y:    y_reg   <= rnd_sat;
            WB_PX:   px_reg  <= rnd_sat;
            WB_PY:   py_reg  <= rnd_sat;
            WB_PXY:  pxy_reg <= rnd_sat;
            WB_ACC:  acc_reg <= acc_reg + ACC_W'(rnd);
            default: ;
        endcase
        if (ctl.done)
        begin
            result_reg.poly_value <= acc_sat;
            result_reg.overflow   <= ovf_reg | ~acc_fits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.done;
        end
    end

    assign stat.i_last = (i_reg == cfg.az_order);
    assign stat.j_last = (j_reg == cfg.rg_order);
    assign done        = done_reg;
    assign result      = result_reg;

endmodule

// ===== hw/rtl/poly2d_evaluator.sv =====
// Channel  | Ports                           | Transfer
// ---------+---------------------------------+------------------------------------
// command  | start, busy, cmd                | clk edge with start high, busy low
// result   | done, result                    | clk edge ending the cycle done is high
// config   | cfg_we, cfg_index, cfg_data     | clk edge with cfg_we high
//
// A coefficient write gives no result; busy stays low.
// An evaluation holds busy until its result is ready; one shared 33x32
// multiplier with a registered product serves every multiply step, and
// done is high in the first cycle busy is low. rst_n resets the step counter;
// configuration resets to zero, inverse scales to FX_ONE; coefficients are undefined.
// The result is never stalled: done is a one-cycle strobe.
module poly2d_evaluator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  p2d_pkg::cmd_t                      cmd,
    output logic                               done,
    output p2d_pkg::result_t                   result,
    input  logic                               cfg_we,
    input  logic [p2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p2d_pkg::DATA_W-1:0]         cfg_data
);
    import p2d_pkg::*;

    cfg_t  cfg_reg;
    ctl_t  ctl;
    stat_t stat;
    logic  accept;
    logic  go;
    logic  coef_we;

    assign accept  = start && !busy;
    assign go      = accept && (cmd.opcode == OP_EVAL);
    assign coef_we = accept && (cmd.opcode == OP_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.az_order <= '0;
            cfg_reg.rg_order <= '0;
            cfg_reg.mean_rg  <= '0;
            cfg_reg.mean_az  <= '0;
            cfg_reg.inv_rg   <= FX_ONE;
            cfg_reg.inv_az   <= FX_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AZ_ORDER: cfg_reg.az_order <= cfg_data[ORD_W-1:0];
                REG_RG_ORDER: cfg_reg.rg_order <= cfg_data[ORD_W-1:0];
                REG_MEAN_RG:  cfg_reg.mean_rg  <= cfg_data;
                REG_MEAN_AZ:  cfg_reg.mean_az  <= cfg_data;
                REG_INV_RG:   cfg_reg.inv_rg   <= cfg_data;
                REG_INV_AZ:   cfg_reg.inv_az   <= cfg_data;
                default: ;
            endcase
        end
    end

    p2d_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    p2d_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .eval_load (go),
        .coef_we   (coef_we),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a running evaluation");

    a_busy_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && cmd.opcode == OP_EVAL))
        else $error("sequencer started without an evaluate transfer");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule
